/* rtl/ccs_pkg.sv */
// Shared types and constants of the Chaikin curve subdivider.
// Used by ccs_mix_unit, chaikin_curve_subdivider_top and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

  // coordinate formats
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 10;
  localparam int PT_W       = 20;

  // level cascade
  localparam int MAX_LEVELS = 5;
  localparam int LV_W       = 3;
  localparam logic [LV_W-1:0] LEVEL_COUNT_RESET = 3'd5;

  // per-level phase codes
  localparam logic [1:0] PH_FIRST       = 2'd0;
  localparam logic [1:0] PH_AFTER_FIRST = 2'd1;
  localparam logic [1:0] PH_INSIDE      = 2'd2;

  // stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_LEVEL_COUNT = 1'b0;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
  } xy_t;

endpackage

`default_nettype wire

/* rtl/chaikin_curve_subdivider_top.sv */
// Top level of the Chaikin curve subdivider: sequencer, level state, ports.
// Depends on ccs_pkg and ccs_mix_unit.
//
// Usage:
//   Control points of an open polyline arrive on the in_ stream, one per
//   transfer; in_tlast marks the last point of a curve. Smoothed points leave
//   on the out_ stream; out_tlast marks the final point of the smoothed curve.
//   The cfg_ port holds level_count (offset 0), the number of corner-cutting
//   passes, 0 to 5 (larger values act as 5).
//   One input point is walked depth first through the levels by a sequencer
//   that shares a single quarter-mix unit. After the accept, each level step
//   takes the S_LEVEL state, followed by S_CUT when the level sits inside a
//   curve and splits the point in two; each result then passes an end check
//   in S_LEVEL and is loaded into the output register in S_EMIT. in_tready is
//   low from the accept until the last result is loaded into the output
//   register.
//   Results pass through one output register, so the sequencer stalls only
//   while out_tvalid is high and out_tready is low; the next input item is
//   accepted while the last result still waits.
//   Reset clears all level phases to start of curve, level_count to 5 and
//   the output register to empty.
`timescale 1ns / 1ps
`default_nettype none

module chaikin_curve_subdivider_top (
  input  wire                                clk,
  input  wire                                rst_n,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [ccs_pkg::IN_TDATA_W-1:0]     in_tdata,   // point_x, point_y, zero pad
  input  wire                                in_tlast,   // end_of_curve
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [ccs_pkg::OUT_TDATA_W-1:0]    out_tdata,  // out_x, out_y
  output logic                               out_tlast,  // last_point
  // configuration port
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [ccs_pkg::CFG_AW-1:0]         cfg_paddr,
  input  wire  [ccs_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [ccs_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  localparam int PT_W = ccs_pkg::PT_W;
  localparam int LV_W = ccs_pkg::LV_W;
  localparam int NLV  = ccs_pkg::MAX_LEVELS;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LEVEL = 2'd1;
  localparam logic [1:0] S_CUT   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LV_W-1:0]  lv_r, lv_nxt;
  logic [LV_W-1:0]  level_count_r;
  logic [LV_W-1:0]  levels;

  ccs_pkg::xy_t     cur_r;
  logic             cur_last_r;

  ccs_pkg::xy_t     held_r [NLV];
  logic [1:0]       phase_r [NLV];
  ccs_pkg::xy_t     pend_r [NLV];
  logic             pend_last_r [NLV];
  logic [NLV-1:0]   pend_v_r;

  ccs_pkg::xy_t     held_cur;
  logic [1:0]       phase_cur;
  logic [1:0]       phase_upd;
  ccs_pkg::xy_t     mix_one, mix_three, mix_res;
  logic [LV_W-1:0]  pop_idx;

  logic             in_xfer;
  logic             cfg_wr;
  logic             out_load;
  logic             at_end;
  logic             lvl_finish;
  logic             lvl_split;

  ccs_pkg::xy_t     in_pt;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[ccs_pkg::CFG_AW-1:2] == ccs_pkg::REG_LEVEL_COUNT);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[ccs_pkg::CFG_AW-1:2] == ccs_pkg::REG_LEVEL_COUNT) begin
      cfg_prdata = ccs_pkg::CFG_DW'(level_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= ccs_pkg::LEVEL_COUNT_RESET;
    end else if (cfg_wr) begin
      level_count_r <= cfg_pwdata[LV_W-1:0];
    end
  end

  // saturate the pass count
  assign levels = (level_count_r > LV_W'(NLV)) ? LV_W'(NLV) : level_count_r;

  // input conversion to fixed point
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_pt.x   = PT_W'(in_tdata[ccs_pkg::COORD_BITS-1:0]) << ccs_pkg::FRAC_BITS;
  assign in_pt.y   = PT_W'(in_tdata[2*ccs_pkg::COORD_BITS-1:ccs_pkg::COORD_BITS])
                     << ccs_pkg::FRAC_BITS;

  // state of the level being worked on
  assign held_cur  = held_r[lv_r];
  assign phase_cur = phase_r[lv_r];
  assign at_end    = (lv_r == levels);

  // next phase of the current level once its point is consumed
  always_comb begin
    if (cur_last_r) begin
      phase_upd = ccs_pkg::PH_FIRST;
    end else if (phase_cur == ccs_pkg::PH_AFTER_FIRST || phase_cur == ccs_pkg::PH_INSIDE) begin
      phase_upd = ccs_pkg::PH_INSIDE;
    end else begin
      phase_upd = ccs_pkg::PH_AFTER_FIRST;
    end
  end

  // shared mix unit: 3/4-1/4 point in the cut step, 1/4-3/4 point otherwise
  always_comb begin
    if (state_r == S_CUT) begin
      mix_one   = cur_r;
      mix_three = held_cur;
    end else begin
      mix_one   = held_cur;
      mix_three = cur_r;
    end
  end

  ccs_mix_unit u_mix (
    .one   (mix_one),
    .three (mix_three),
    .mix   (mix_res)
  );

  // deepest level with a waiting second point
  always_comb begin
    pop_idx = '0;
    for (int i = 0; i < NLV; i++) begin
      if (pend_v_r[i]) begin
        pop_idx = LV_W'(i);
      end
    end
  end

  assign out_load   = (state_r == S_EMIT) && (!out_tvalid || out_tready);
  assign lvl_split  = (state_r == S_LEVEL) && !at_end && (phase_cur == ccs_pkg::PH_INSIDE);
  assign lvl_finish = ((state_r == S_LEVEL) && !at_end && (phase_cur != ccs_pkg::PH_INSIDE)) ||
                      (state_r == S_CUT);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    lv_nxt    = lv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_LEVEL;
          lv_nxt    = '0;
        end
      end
      S_LEVEL: begin
        if (at_end) begin
          state_nxt = S_EMIT;
        end else if (phase_cur == ccs_pkg::PH_INSIDE) begin
          state_nxt = S_CUT;
        end else begin
          lv_nxt = lv_r + LV_W'(1);
        end
      end
      S_CUT: begin
        state_nxt = S_LEVEL;
        lv_nxt    = lv_r + LV_W'(1);
      end
      S_EMIT: begin
        if (out_load) begin
          if (|pend_v_r) begin
            state_nxt = S_LEVEL;
            lv_nxt    = pop_idx + LV_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      lv_r     <= '0;
      pend_v_r <= '0;
      for (int i = 0; i < NLV; i++) begin
        phase_r[i] <= ccs_pkg::PH_FIRST;
      end
    end else begin
      state_r <= state_nxt;
      lv_r    <= lv_nxt;
      if (lvl_split) begin
        pend_v_r[lv_r] <= 1'b1;
      end else if (out_load && (|pend_v_r)) begin
        pend_v_r[pop_idx] <= 1'b0;
      end
      if (lvl_finish) begin
        phase_r[lv_r] <= phase_upd;
      end
    end
  end

  // point payload: current point, held points, waiting second points
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_r      <= in_pt;
      cur_last_r <= in_tlast;
    end else if (lvl_split) begin
      // second point of an inside segment waits for its turn
      pend_r[lv_r]      <= cur_last_r ? cur_r : mix_res;
      pend_last_r[lv_r] <= cur_last_r;
    end else if (lvl_finish) begin
      held_r[lv_r] <= cur_r;
      if (state_r == S_CUT) begin
        cur_r      <= mix_res;
        cur_last_r <= 1'b0;
      end else if (phase_cur == ccs_pkg::PH_AFTER_FIRST && !cur_last_r) begin
        cur_r <= mix_res;
      end
    end else if (out_load && (|pend_v_r)) begin
      cur_r      <= pend_r[pop_idx];
      cur_last_r <= pend_last_r[pop_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata <= {cur_r.y, cur_r.x};
      out_tlast <= cur_last_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/ccs_mix_unit.sv */
// Shared quarter-mix unit: (one + 3 * three) / 4 on both coordinates.
// Depends on ccs_pkg for the point type and widths.
`timescale 1ns / 1ps
`default_nettype none

module ccs_mix_unit (
  input  ccs_pkg::xy_t one,
  input  ccs_pkg::xy_t three,
  output ccs_pkg::xy_t mix
);

  localparam int SUM_W = ccs_pkg::PT_W + 2;

  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;

  // one + 2*three + three, then drop the two low bits
  assign sum_x = SUM_W'(one.x) + (SUM_W'(three.x) << 1) + SUM_W'(three.x);
  assign sum_y = SUM_W'(one.y) + (SUM_W'(three.y) << 1) + SUM_W'(three.y);

  assign mix.x = sum_x[SUM_W-1:2];
  assign mix.y = sum_y[SUM_W-1:2];

endmodule

`default_nettype wire

/* tb/sv/chaikin_smooth_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the Chaikin curve subdivider: tracks level_count, predicts the
// smoothed points of every accepted control point and checks each result transfer.
// Depends on ccs_pkg.

module chaikin_smooth_checker
  import ccs_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  input  wire                    in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // point_x, point_y, zero pad
  input  wire                    in_tlast,   // end_of_curve
  input  wire                    out_tvalid,
  input  wire                    out_tready,
  input  wire [OUT_TDATA_W-1:0]  out_tdata,  // out_x, out_y
  input  wire                    out_tlast,  // last_point
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [CFG_AW-1:0]       cfg_paddr,
  input  wire [CFG_DW-1:0]       cfg_pwdata,
  input  wire [CFG_DW-1:0]       cfg_prdata,
  input  wire                    cfg_pready,
  output int                     expected_left,
  output int                     fail_count
);

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic            eoc;
  } smooth_pt_t;

  localparam logic [CFG_AW-1:0] LEVEL_ADDR = {REG_LEVEL_COUNT, 2'b00};

  // per-level corner state and the register copy
  logic [PT_W-1:0] held_x    [MAX_LEVELS];
  logic [PT_W-1:0] held_y    [MAX_LEVELS];
  logic [1:0]      lvl_phase [MAX_LEVELS];
  logic [LV_W-1:0] level_setting;
  smooth_pt_t      smoothed_q[$];
  int              mismatch_total = 0;

  assign fail_count = mismatch_total;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_total < 40)
      $display("%0t ns mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatch_total++;
  endtask

  // (one + 3*three) / 4, exact in the fraction bits
  function automatic logic [PT_W-1:0] quarter_blend(input logic [PT_W-1:0] one,
                                                    input logic [PT_W-1:0] three);
    logic [31:0] sum;
    sum = 32'(one) + 32'(three) * 32'd3;
    return sum[PT_W+1:2];
  endfunction

  // one corner-cutting level, endpoints kept
  function automatic void cut_level(input int lv, input smooth_pt_t p,
                                    ref smooth_pt_t dst[$]);
    smooth_pt_t mid;
    logic [1:0] ph;
    ph      = lvl_phase[lv];
    mid.eoc = 1'b0;
    // 3/4-1/4 point of a segment that is not the first
    if (ph == PH_INSIDE) begin
      mid.x = quarter_blend(p.x, held_x[lv]);
      mid.y = quarter_blend(p.y, held_y[lv]);
      dst.push_back(mid);
    end
    // 1/4-3/4 point, or the point itself at either end of the curve
    if ((ph == PH_AFTER_FIRST || ph == PH_INSIDE) && !p.eoc) begin
      mid.x = quarter_blend(held_x[lv], p.x);
      mid.y = quarter_blend(held_y[lv], p.y);
      dst.push_back(mid);
    end else begin
      dst.push_back(p);
    end
    if (p.eoc)
      lvl_phase[lv] = PH_FIRST;
    else if (ph == PH_AFTER_FIRST || ph == PH_INSIDE)
      lvl_phase[lv] = PH_INSIDE;
    else
      lvl_phase[lv] = PH_AFTER_FIRST;
    held_x[lv] = p.x;
    held_y[lv] = p.y;
  endfunction

  // walk one control point through the active levels
  function automatic void smooth_point(input logic [COORD_BITS-1:0] px,
                                       input logic [COORD_BITS-1:0] py,
                                       input logic eoc);
    smooth_pt_t stage[$];
    smooth_pt_t next_stage[$];
    smooth_pt_t start;
    int         levels;
    levels    = (level_setting > MAX_LEVELS) ? MAX_LEVELS : int'(level_setting);
    start.x   = PT_W'(px) << FRAC_BITS;
    start.y   = PT_W'(py) << FRAC_BITS;
    start.eoc = eoc;
    stage.push_back(start);
    for (int lv = 0; lv < levels; lv++) begin
      next_stage.delete();
      foreach (stage[i]) cut_level(lv, stage[i], next_stage);
      stage = next_stage;
    end
    foreach (stage[i]) smoothed_q.push_back(stage[i]);
  endfunction

  // watch all three ports each edge
  always @(posedge clk) begin
    smooth_pt_t got;
    smooth_pt_t want;
    if (!rst_n) begin
      for (int lv = 0; lv < MAX_LEVELS; lv++) begin
        held_x[lv]    = '0;
        held_y[lv]    = '0;
        lvl_phase[lv] = PH_FIRST;
      end
      level_setting = LEVEL_COUNT_RESET;
      smoothed_q.delete();
    end else begin
      // register write or readback
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == LEVEL_ADDR) begin
        if (cfg_pwrite)
          level_setting = cfg_pwdata[LV_W-1:0];
        else if (cfg_prdata !== CFG_DW'(level_setting))
          flag_mismatch("level_count readback", cfg_prdata, CFG_DW'(level_setting));
      end
      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.x   = out_tdata[PT_W-1:0];
        got.y   = out_tdata[2*PT_W-1:PT_W];
        got.eoc = out_tlast;
        if (smoothed_q.size() == 0) begin
          flag_mismatch("result with no point pending, out_x", got.x, '0);
        end else begin
          want = smoothed_q.pop_front();
          if (got.x !== want.x) flag_mismatch("out_x", got.x, want.x);
          if (got.y !== want.y) flag_mismatch("out_y", got.y, want.y);
          if (got.eoc !== want.eoc) flag_mismatch("last_point", got.eoc, want.eoc);
        end
      end
      // control point transfer
      if (in_tvalid && in_tready)
        smooth_point(in_tdata[COORD_BITS-1:0], in_tdata[2*COORD_BITS-1:COORD_BITS],
                     in_tlast);
    end
    expected_left <= smoothed_q.size();
  end

endmodule

/* tb/sv/tb_chaikin_curve_subdivider_top.sv */
`timescale 1ns / 1ps
// Testbench top for the Chaikin curve subdivider: clock, reset, control point
// and register stimulus, result-side stalls and the verdict.
// Depends on ccs_pkg, chaikin_curve_subdivider_top and chaikin_smooth_checker.

module tb_chaikin_curve_subdivider_top;
  import ccs_pkg::*;

  localparam logic [CFG_AW-1:0] LEVEL_ADDR = {REG_LEVEL_COUNT, 2'b00};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // point_x, point_y, zero pad
  logic                   in_tlast;   // end_of_curve
  wire                    out_tvalid;
  logic                   out_tready;
  wire [OUT_TDATA_W-1:0]  out_tdata;  // out_x, out_y
  wire                    out_tlast;  // last_point
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  wire [CFG_DW-1:0]       cfg_prdata;
  wire                    cfg_pready;
  int                     expected_left;
  int                     fail_count;

  logic                   long_hold_req;
  bit                     steady_feed = 1'b0;
  int                     points_sent = 0;
  int unsigned            level_sweep[8] = '{0, 7, 1, 5, 3, 6, 2, 4};

  chaikin_curve_subdivider_top DUT (.*);

  chaikin_smooth_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    bit hold_taken;
    int roll;
    hold_taken = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      out_tready <= 1'b1;
      roll = $urandom_range(0, 9);
      repeat ((roll == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30))
        @(posedge clk);
      out_tready <= 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 70)      repeat ($urandom_range(1, 2)) @(posedge clk);
      else if (roll < 95) repeat ($urandom_range(3, 8)) @(posedge clk);
      else                repeat ($urandom_range(20, 60)) @(posedge clk);
    end
  end

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return COORD_BITS'($urandom);
  endfunction

  // one control point transfer, then a random gap (none while steady_feed is set)
  task automatic push_point(input logic [COORD_BITS-1:0] px,
                            input logic [COORD_BITS-1:0] py, input logic eoc);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({py, px});
    in_tlast  <= eoc;
    do @(posedge clk); while (!in_tready);
    points_sent++;
    gap = $urandom_range(0, 99);
    if (steady_feed || gap < 60) gap = 0;
    else if (gap < 90)           gap = $urandom_range(1, 3);
    else if (gap < 98)           gap = $urandom_range(4, 12);
    else                         gap = $urandom_range(30, 80);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_left != 0);
  endtask

  // apb setup and access phases, then back to idle
  task automatic cfg_access(input logic write, input logic [CFG_DW-1:0] data);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= write;
    cfg_paddr  <= LEVEL_ADDR;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // new level count once all results are out, then read it back
  task automatic set_levels(input int unsigned lvl);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_access(1'b1, CFG_DW'(lvl));
    cfg_access(1'b0, '0);
  endtask

  initial begin
    int phase_end;
    int kind;
    int len;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tlast      <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    long_hold_req <= 1'b0;
    rst_n         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset level count: single point, two-point and longer curves
    push_point('1, '1, 1'b1);
    push_point('0, '0, 1'b0);
    push_point('1, '1, 1'b1);
    push_point(10'd0, 10'd1023, 1'b0);
    push_point(10'd1023, 10'd0, 1'b0);
    push_point(10'h2AA, 10'h155, 1'b1);
    push_point(10'd1, 10'd2, 1'b0);
    push_point(10'd512, 10'd256, 1'b0);
    push_point(10'd1023, 10'd1023, 1'b0);
    push_point(10'd0, 10'd0, 1'b1);
    // no levels: straight conversion
    set_levels(0);
    push_point(10'd5, 10'd9, 1'b0);
    push_point(10'd1023, 10'd0, 1'b1);
    push_point(10'd7, 10'd7, 1'b1);
    // above the maximum: saturates
    set_levels(7);
    push_point(10'd0, 10'd0, 1'b0);
    push_point(10'd1023, 10'd1023, 1'b0);
    push_point(10'd0, 10'd1023, 1'b1);
    // level count raised in the middle of a curve
    set_levels(1);
    push_point(10'd100, 10'd200, 1'b0);
    push_point(10'd300, 10'd400, 1'b0);
    set_levels(3);
    push_point(10'd500, 10'd600, 1'b0);
    push_point(10'd1023, 10'd1023, 1'b1);

    // random curves, a new level count per phase
    for (int phase = 0; points_sent < 470; phase++) begin
      set_levels((phase < 8) ? level_sweep[phase] : $urandom_range(0, 7));
      steady_feed = (phase % 4 == 2);
      if (phase == 3) long_hold_req <= 1'b1;
      phase_end = points_sent + $urandom_range(10, 40);
      while (points_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 90) begin
          len = (kind < 15) ? 1 : (kind < 80) ? $urandom_range(2, 8) : $urandom_range(9, 20);
          for (int i = 0; i < len; i++)
            push_point(pick_coord(), pick_coord(), i == len - 1);
        end else begin
          // end marks at random
          repeat ($urandom_range(2, 6))
            push_point(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        end
      end
      // sometimes leave a curve open across the next level change
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) push_point(pick_coord(), pick_coord(), 1'b0);
    end
    in_tvalid <= 1'b0;

    // drain, then a tail for stray results
    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expected_left == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
